[src/u2b_pkg.sv]
// Shared types, constants and braille lookup functions for the UTF-8 to braille block.
package u2b_pkg;

    localparam logic [7:0] DOT_Q = 8'h26;  // '?'
    localparam logic [7:0] DOT_8 = 8'h80;

    // One decode request handed from the front to the back.
    typedef struct packed {
        logic        has_cp;   // a code point to turn into a cell
        logic [20:0] cp;
        logic        bad;      // emit '?' instead of the code point
        logic        last;     // final request of the text
        logic        fin;      // request comes from the byte that ends the text
    } t_req;

    function automatic logic [7:0] letter_dots(input logic [4:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                5'd0: r = 8'h01;  5'd1: r = 8'h03;  5'd2: r = 8'h09;  5'd3: r = 8'h19;
                5'd4: r = 8'h11;  5'd5: r = 8'h0B;  5'd6: r = 8'h1B;  5'd7: r = 8'h13;
                5'd8: r = 8'h0A;  5'd9: r = 8'h1A;  5'd10: r = 8'h05; 5'd11: r = 8'h07;
                5'd12: r = 8'h0D; 5'd13: r = 8'h1D; 5'd14: r = 8'h15; 5'd15: r = 8'h0F;
                5'd16: r = 8'h1F; 5'd17: r = 8'h17; 5'd18: r = 8'h0E; 5'd19: r = 8'h1E;
                5'd20: r = 8'h25; 5'd21: r = 8'h27; 5'd22: r = 8'h3A; 5'd23: r = 8'h2D;
                5'd24: r = 8'h3D; 5'd25: r = 8'h35;
                default: r = 8'h00;
            endcase
            letter_dots = r;
        end
    endfunction

    function automatic logic [7:0] ascii_dots(input logic [6:0] c);
        logic [7:0] r;
        begin
            if (c == 7'h20 || c == 7'h0A || c == 7'h0D || c == 7'h09) r = 8'h00;
            else if (c >= 7'h61 && c <= 7'h7A) r = letter_dots(5'(c - 7'h61));
            else if (c >= 7'h41 && c <= 7'h5A) r = letter_dots(5'(c - 7'h41)) | 8'h40;
            else if (c >= 7'h31 && c <= 7'h39) r = letter_dots(5'(c - 7'h31)) | 8'h20;
            else begin
                case (c)
                    7'h30: r = 8'h3A;
                    7'h2E: r = 8'h32;
                    7'h2C: r = 8'h02;
                    7'h3B: r = 8'h06;
                    7'h3A: r = 8'h12;
                    7'h21: r = 8'h16;
                    7'h3F: r = 8'h26;
                    7'h2D: r = 8'h24;
                    7'h27: r = 8'h04;
                    7'h22: r = 8'h34;
                    7'h28, 7'h29: r = 8'h36;
                    7'h2F: r = 8'h0C;
                    7'h5C: r = 8'h33;
                    7'h2B: r = 8'h16;
                    7'h3D: r = 8'h3F;
                    7'h2A: r = 8'h21;
                    7'h26: r = 8'h2F;
                    7'h25: r = 8'h29;
                    7'h40: r = 8'h48;
                    7'h23: r = 8'h3C;
                    7'h5B, 7'h3C: r = 8'h23;
                    7'h5D, 7'h3E: r = 8'h1C;
                    7'h5F: r = 8'h38;
                    default: r = DOT_8;
                endcase
            end
            ascii_dots = r;
        end
    endfunction

    function automatic logic [7:0] deva_dots(input logic [6:0] lo);
        logic [7:0] r;
        begin
            case (lo)
                7'h05, 7'h06, 7'h3E: r = 8'h01;
                7'h07, 7'h08, 7'h3F, 7'h40: r = 8'h0A;
                7'h09, 7'h0A, 7'h41, 7'h42: r = 8'h25;
                7'h0F, 7'h47: r = 8'h11;
                7'h10: r = 8'h51;
                7'h13, 7'h14, 7'h4B, 7'h4C: r = 8'h15;
                7'h0B, 7'h43, 7'h30: r = 8'h17;
                7'h15, 7'h16: r = 8'h05;
                7'h17, 7'h18: r = 8'h1B;
                7'h1A, 7'h1B: r = 8'h09;
                7'h1C, 7'h1D: r = 8'h1A;
                7'h1F, 7'h20, 7'h24, 7'h25: r = 8'h1E;
                7'h21, 7'h22, 7'h26, 7'h27: r = 8'h19;
                7'h23, 7'h28: r = 8'h1D;
                7'h2A: r = 8'h0F;
                7'h2B: r = 8'h0B;
                7'h2C, 7'h2D: r = 8'h03;
                7'h2E: r = 8'h0D;
                7'h2F: r = 8'h3D;
                7'h32: r = 8'h07;
                7'h35: r = 8'h27;
                7'h36, 7'h37, 7'h38: r = 8'h0E;
                7'h39: r = 8'h13;
                7'h01, 7'h02, 7'h03: r = 8'h14;
                7'h4D: r = 8'h08;
                7'h64, 7'h65: r = 8'h32;
                default: r = DOT_8;
            endcase
            deva_dots = r;
        end
    endfunction

    function automatic logic [7:0] cell_for(input logic [20:0] cp);
        logic [7:0] r;
        begin
            if (cp < 21'h80) r = ascii_dots(cp[6:0]);
            else if (cp >= 21'h900 && cp <= 21'h97F) r = deva_dots(cp[6:0]);
            else r = DOT_8;
            cell_for = r;
        end
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] r;
        begin
            if (b[7] == 1'b0) r = 3'd1;
            else if ((b & 8'hE0) == 8'hC0) r = 3'd2;
            else if ((b & 8'hF0) == 8'hE0) r = 3'd3;
            else if ((b & 8'hF8) == 8'hF0) r = 3'd4;
            else r = 3'd0;
            lead_len = r;
        end
    endfunction

    function automatic logic [20:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] len);
        logic [20:0] r;
        begin
            case (len)
                3'd2: r = {10'd0, b0[4:0], b1[5:0]};
                3'd3: r = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                3'd4: r = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                default: r = {13'd0, b0};
            endcase
            decode = r;
        end
    endfunction

endpackage

[src/u2b_front.sv]
// Front end: assembles UTF-8 sequences and issues up to three decode requests per byte.
module u2b_front
    import u2b_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_take,
    output logic [1:0] o_nreq,
    output t_req       o_req0,
    output t_req       o_req1,
    output t_req       o_req2
);
    logic [7:0] r_pend [3];
    logic [1:0] r_pcnt;
    logic [2:0] r_slen;
    logic [1:0] n_pcnt;
    logic [2:0] n_slen;

    logic [7:0] b;
    logic       eot;
    logic       fin;
    t_req       rq [3];
    logic [1:0] nr;
    logic [1:0] fcnt;   // pending bytes left for the end-of-text flush
    logic [2:0] l1, l2;
    logic [7:0] p1, p2;

    assign b   = i_text_byte;
    assign fin = (b == 8'd0) || i_end_of_text;
    assign eot = fin;
    assign o_take = i_push;

    // The byte taken this cycle may itself be the newest pending byte.
    assign p1 = (r_pcnt == 2'd1) ? b : r_pend[1];
    assign p2 = (r_pcnt == 2'd2) ? b : r_pend[2];

    always_comb begin
        n_pcnt = r_pcnt;
        n_slen = r_slen;
        nr = 2'd0;
        fcnt = 2'd0;
        for (int k = 0; k < 3; k++) rq[k] = '0;
        // Step the byte through the sequence assembler.
        if (b != 8'd0) begin
            if (r_pcnt == 2'd0) begin
                if (lead_len(b) == 3'd1) begin
                    rq[0].has_cp = 1'b1; rq[0].cp = {13'd0, b}; nr = 2'd1;
                end else if (lead_len(b) == 3'd0) begin
                    rq[0].bad = 1'b1; nr = 2'd1;
                end else begin
                    n_pcnt = 2'd1; n_slen = lead_len(b);
                end
            end else if ({1'b0, r_pcnt} + 3'd1 >= r_slen) begin
                rq[0].has_cp = 1'b1;
                rq[0].cp = decode(r_pend[0], (r_pcnt == 2'd1) ? b : r_pend[1],
                                  (r_pcnt == 2'd2) ? b : r_pend[2], b, {1'b0, r_pcnt} + 3'd1);
                nr = 2'd1;
                n_pcnt = 2'd0; n_slen = 3'd0;
            end else begin
                n_pcnt = r_pcnt + 2'd1;
            end
        end
        // Flush a truncated sequence at end of text: lead gives '?', rest re-decoded.
        l1 = 3'd0; l2 = 3'd0;
        if (eot) begin
            fcnt = (b != 8'd0) ? n_pcnt : r_pcnt;
            if (fcnt != 2'd0) begin
                rq[nr].bad = 1'b1;
                nr = nr + 2'd1;
                l1 = lead_len(p1);
                l2 = lead_len(p2);
                if (fcnt >= 2'd2) begin
                    if (l1 == 3'd1) begin
                        rq[nr].has_cp = 1'b1; rq[nr].cp = {13'd0, p1};
                        nr = nr + 2'd1;
                        if (fcnt == 2'd3) begin
                            if (l2 == 3'd1) begin
                                rq[nr].has_cp = 1'b1; rq[nr].cp = {13'd0, p2};
                            end else begin
                                rq[nr].bad = 1'b1;
                            end
                            nr = nr + 2'd1;
                        end
                    end else if (l1 == 3'd2 && fcnt == 2'd3) begin
                        rq[nr].has_cp = 1'b1;
                        rq[nr].cp = decode(p1, p2, 8'd0, 8'd0, 3'd2);
                        nr = nr + 2'd1;
                    end else begin
                        rq[nr].bad = 1'b1;
                        nr = nr + 2'd1;
                        if (fcnt == 2'd3) begin
                            if (l2 == 3'd1) begin
                                rq[nr].has_cp = 1'b1; rq[nr].cp = {13'd0, p2};
                            end else begin
                                rq[nr].bad = 1'b1;
                            end
                            nr = nr + 2'd1;
                        end
                    end
                end
            end
            n_pcnt = 2'd0; n_slen = 3'd0;
        end
        // A text end always yields at least one word (a bare marker if needed).
        if (eot) begin
            for (int k = 0; k < 3; k++) rq[k].fin = 1'b1;
            if (nr == 2'd0) nr = 2'd1;
            rq[nr - 2'd1].last = 1'b1;
        end
    end

    assign o_nreq = nr;
    assign o_req0 = rq[0];
    assign o_req1 = rq[1];
    assign o_req2 = rq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
            r_slen <= 3'd0;
        end else if (i_push) begin
            r_pcnt <= n_pcnt;
            r_slen <= n_slen;
        end
    end

    // Hold pending bytes; entries are read only after being written in the text.
    always_ff @(posedge i_clk) begin
        if (i_push && b != 8'd0 && n_pcnt != 2'd0) r_pend[n_pcnt - 2'd1] <= b;
    end
endmodule

[src/u2b_back.sv]
// Back end: maps queued requests to cells, applies the cell limit, numbers cells.
module u2b_back
    import u2b_pkg::*;
#(
    parameter int CELL_LIMIT = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [6:0] i_max_cells,
    input  logic       i_valid,
    input  t_req       i_req,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_cell_pattern,
    output logic       o_has_cell,
    output logic [6:0] o_cell_index,
    output logic       o_text_done,
    input  logic       i_ready
);
    localparam int CW = $clog2(CELL_LIMIT + 1);
    logic [CW-1:0] r_cnt;
    logic          r_fin_emit;  // a cell was kept earlier for the text-ending byte
    logic          r_ov;
    logic [7:0]    r_pat;
    logic          r_has;
    logic [6:0]    r_idx;
    logic          r_done;

    logic [CW-1:0] lim;
    logic          room;
    logic          emit;
    logic          at_lim;
    logic          produce;
    logic          n_ov;
    logic [7:0]    pat;

    always_comb begin
        if (i_max_cells == 7'd0) lim = CW'(1);
        else if ({25'd0, i_max_cells} > CELL_LIMIT) lim = CW'(CELL_LIMIT);
        else lim = CW'(i_max_cells);
    end

    assign room    = r_cnt < lim;
    assign at_lim  = (r_cnt + CW'(1)) >= lim;
    assign pat     = i_req.bad ? DOT_Q : cell_for(i_req.cp);
    assign emit    = (i_req.has_cp || i_req.bad) && room;
    // A last request produces a word if it emits, or if the ending byte kept no cell.
    assign produce = emit || (i_req.last && !r_fin_emit);
    assign o_ready = !r_ov || i_ready;
    assign n_ov    = (i_valid && o_ready && produce) || (r_ov && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_fin_emit <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_ov <= n_ov;
            if (i_valid && o_ready) begin
                if (i_req.last) begin
                    r_cnt <= '0; r_fin_emit <= 1'b0;
                end else if (emit) begin
                    r_cnt <= r_cnt + CW'(1); r_fin_emit <= i_req.fin;
                end
            end
        end
    end

    // An ending byte's cell that fills the display is the last word of the text.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && produce) begin
            r_pat  <= emit ? pat : 8'd0;
            r_has  <= emit;
            r_idx  <= emit ? 7'(r_cnt) : 7'd0;
            r_done <= i_req.last || (i_req.fin && at_lim);
        end
    end

    assign o_valid        = r_ov;
    assign o_cell_pattern = r_pat;
    assign o_has_cell     = r_has;
    assign o_cell_index   = r_idx;
    assign o_text_done    = r_done;
endmodule

[src/utf8_text_to_braille_cells.sv]
// Top level of the UTF-8 text to eight-dot braille cell converter.
// Push one text byte per word; a zero byte or end_of_text closes the text. The front
// decodes the byte in the cycle it is taken and drops up to three requests into an
// eight-entry queue; it takes a byte only while the queue has room for three. The back
// retires one request per cycle while words are popped as they come and delivers at
// most one word per request (cells past the display width are dropped), so ASCII and
// complete sequences then sustain one byte per cycle. A byte's first word passes the
// request queue and the back-end output register before it can be popped. A waiting
// word holds its value until popped. Write max_cells only while idle.
module utf8_text_to_braille_cells
    import u2b_pkg::*;
#(
    parameter int CELL_LIMIT = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_cell_pattern,
    output logic       o_has_cell,
    output logic [6:0] o_cell_index,
    output logic       o_text_done,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);
    localparam int QD = 8;
    logic [6:0] r_max;
    t_req       r_q [QD];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_cnt;
    logic       take;
    logic [1:0] nreq;
    t_req       q0, q1, q2;
    logic       acc;
    logic       bvalid, bready;
    logic       ovalid;
    logic [3:0] n_cnt;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max <= 7'd20;
        else if (i_cfg_we) r_max <= i_cfg_wdata;
    end

    assign full = r_cnt > 4'(QD - 3);
    assign acc  = push && !full;

    u2b_front u_front (
        .i_clk, .i_rst_n, .i_push(acc), .i_text_byte, .i_end_of_text,
        .o_take(take), .o_nreq(nreq), .o_req0(q0), .o_req1(q1), .o_req2(q2)
    );

    assign bvalid = r_cnt != 4'd0;

    u2b_back #(.CELL_LIMIT(CELL_LIMIT)) u_back (
        .i_clk, .i_rst_n, .i_max_cells(r_max), .i_valid(bvalid), .i_req(r_q[r_rp]),
        .o_ready(bready), .o_valid(ovalid), .o_cell_pattern, .o_has_cell, .o_cell_index,
        .o_text_done, .i_ready(pop)
    );

    assign empty = !ovalid;

    // Request queue between front and back.
    always_comb begin
        n_cnt = r_cnt + (take ? {2'd0, nreq} : 4'd0) - ((bvalid && bready) ? 4'd1 : 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (take) r_wp <= r_wp + 3'(nreq);
            if (bvalid && bready) r_rp <= r_rp + 3'd1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (nreq != 2'd0) r_q[r_wp] <= q0;
            if (nreq >= 2'd2) r_q[r_wp + 3'd1] <= q1;
            if (nreq == 2'd3) r_q[r_wp + 3'd2] <= q2;
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 4'(QD))
        else $error("queue overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> r_cnt > 4'd5) else $error("full wrong");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_cell_pattern) && $stable(o_text_done)))
        else $error("waiting word changed");
`endif
endmodule

[verif/utf8_text_to_braille_cells_test.sv]
// Testbench for the UTF-8 text to braille cell converter: random and directed texts, self-checked.
module utf8_text_to_braille_cells_test;
    import u2b_pkg::*;

    // One byte of text as the sender hands it over.
    typedef struct {
        logic [7:0] text_byte;
        logic       eot;
    } t_text_word;

    // One braille result word as the block should deliver it.
    typedef struct {
        logic [7:0] pattern;
        logic       has_cell;
        logic [6:0] index;
        logic       done;
    } t_cell_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_text_byte;
    logic       i_end_of_text;
    logic       empty;
    logic       pop;
    logic [7:0] o_cell_pattern;
    logic       o_has_cell;
    logic [6:0] o_cell_index;
    logic       o_text_done;
    logic       i_cfg_we;
    logic [6:0] i_cfg_wdata;

    utf8_text_to_braille_cells u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .empty          (empty),
        .pop            (pop),
        .o_cell_pattern (o_cell_pattern),
        .o_has_cell     (o_has_cell),
        .o_cell_index   (o_cell_index),
        .o_text_done    (o_text_done),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // Bytes waiting to be driven, and cells the block still owes us.
    t_text_word text_words[$];
    t_cell_word cells_due[$];
    int         error_count = 0;
    bit         no_idle = 0;   // set for stretches with back-to-back words
    int         send_gap = 0;
    int         recv_gap = 0;

    // Shadow of the decoder state and of the width register.
    logic [7:0] pend_bytes [0:3];
    int         pend_count = 0;
    int         seq_len = 0;
    int         cells_shown = 0;
    int         width_reg = 20;
    int         step_cells = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Braille tables
    // ---------------------------------------------------------------
    function automatic logic [7:0] letter_cell(input int n);
        logic [7:0] tbl [0:25];
        tbl = '{8'h01, 8'h03, 8'h09, 8'h19, 8'h11, 8'h0B, 8'h1B, 8'h13, 8'h0A, 8'h1A,
                8'h05, 8'h07, 8'h0D, 8'h1D, 8'h15, 8'h0F, 8'h1F, 8'h17, 8'h0E, 8'h1E,
                8'h25, 8'h27, 8'h3A, 8'h2D, 8'h3D, 8'h35};
        return tbl[n % 26];
    endfunction

    function automatic logic [7:0] cell_of_ascii(input int c);
        if (c == 32) return 8'h00;
        if (c >= 97 && c <= 122) return letter_cell(c - 97);
        if (c >= 65 && c <= 90) return letter_cell(c - 65) | 8'h40;
        if (c >= 49 && c <= 57) return letter_cell(c - 49) | 8'h20;
        case (c)
            "0": return letter_cell(9) | 8'h20;
            ".": return 8'h32;
            ",": return 8'h02;
            ";": return 8'h06;
            ":": return 8'h12;
            "!": return 8'h16;
            "?": return 8'h26;
            "-": return 8'h24;
            "'": return 8'h04;
            "\"": return 8'h34;
            "(", ")": return 8'h36;
            "/": return 8'h0C;
            "\\": return 8'h33;
            "+": return 8'h16;
            "=": return 8'h3F;
            "*": return 8'h21;
            "&": return 8'h2F;
            "%": return 8'h29;
            "@": return 8'h48;
            "#": return 8'h3C;
            "[", "<": return 8'h23;
            "]", ">": return 8'h1C;
            "_": return 8'h38;
            default: return 8'h80;
        endcase
    endfunction

    // Devanagari cells; zero means the code point has no entry.
    function automatic logic [7:0] cell_of_deva(input int cp);
        case (cp)
            'h905, 'h906, 'h93E: return letter_cell(0);
            'h907, 'h908, 'h93F, 'h940: return letter_cell(8);
            'h909, 'h90A, 'h941, 'h942: return letter_cell(20);
            'h90F, 'h947: return letter_cell(4);
            'h910: return letter_cell(4) | 8'h40;
            'h913, 'h914, 'h94B, 'h94C: return letter_cell(14);
            'h90B, 'h943, 'h930: return letter_cell(17);
            'h915, 'h916: return letter_cell(10);
            'h917, 'h918: return letter_cell(6);
            'h91A, 'h91B: return letter_cell(2);
            'h91C, 'h91D: return letter_cell(9);
            'h91F, 'h920, 'h924, 'h925: return letter_cell(19);
            'h921, 'h922, 'h926, 'h927: return letter_cell(3);
            'h923, 'h928: return letter_cell(13);
            'h92A: return letter_cell(15);
            'h92B: return letter_cell(5);
            'h92C, 'h92D: return letter_cell(1);
            'h92E: return letter_cell(12);
            'h92F: return letter_cell(24);
            'h932: return letter_cell(11);
            'h935: return letter_cell(21);
            'h936, 'h937, 'h938: return letter_cell(18);
            'h939: return letter_cell(7);
            'h901, 'h902, 'h903: return 8'h14;
            'h94D: return 8'h08;
            'h964, 'h965: return 8'h32;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] cell_of_point(input int cp);
        logic [7:0] d;
        if (cp == 10 || cp == 13 || cp == 9) return 8'h00;
        if (cp < 'h80) return cell_of_ascii(cp);
        d = cell_of_deva(cp);
        return (d != 8'h00) ? d : 8'h80;
    endfunction

    function automatic int seq_len_of(input logic [7:0] b);
        if (b[7] == 1'b0) return 1;
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    function automatic int point_of(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input int n);
        case (n)
            2: return {b0[4:0], b1[5:0]};
            3: return {b0[3:0], b1[5:0], b2[5:0]};
            4: return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: return b0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task automatic show_cell(input logic [7:0] pat);
        int lim;
        lim = width_reg;
        if (lim < 1) lim = 1;
        if (lim > 80) lim = 80;
        // drop cells past the display width or past three per byte
        if (cells_shown >= lim || step_cells >= 3) return;
        cells_due.push_back('{pat, 1'b1, 7'(cells_shown), 1'b0});
        cells_shown++;
        step_cells++;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int n;
        if (pend_count == 0) begin
            n = seq_len_of(b);
            if (n == 1) show_cell(cell_of_point(b));
            else if (n == 0) show_cell(cell_of_ascii("?"));
            else begin
                pend_bytes[0] = b;
                pend_count = 1;
                seq_len = n;
            end
            return;
        end
        if (pend_count + 1 >= seq_len) begin
            pend_bytes[pend_count] = b;
            show_cell(cell_of_point(point_of(pend_bytes[0], pend_bytes[1], pend_bytes[2],
                                             pend_bytes[3], pend_count + 1)));
            pend_count = 0;
            seq_len = 0;
        end else begin
            pend_bytes[pend_count] = b;
            pend_count++;
        end
    endtask

    // Re-decode an unfinished sequence as text that ends right after it.
    task automatic flush_partial();
        int i;
        int n;
        i = 0;
        while (i < pend_count) begin
            n = seq_len_of(pend_bytes[i]);
            if (n == 1) begin
                show_cell(cell_of_point(pend_bytes[i]));
                i++;
            end else if (n != 0 && i + n <= pend_count) begin
                show_cell(cell_of_point(point_of(pend_bytes[i], pend_bytes[i + 1],
                                                 pend_bytes[i + 2], 8'h00, n)));
                i += n;
            end else begin
                show_cell(cell_of_ascii("?"));
                i++;
            end
        end
    endtask

    task automatic predict_cells(input logic [7:0] b, input logic eot);
        step_cells = 0;
        if (b != 8'h00) absorb_byte(b);
        if (b == 8'h00 || eot) begin
            flush_partial();
            // mark the last cell of the text, or owe a bare end marker
            if (step_cells > 0) cells_due[cells_due.size() - 1].done = 1'b1;
            else cells_due.push_back('{8'h00, 1'b0, 7'd0, 1'b1});
            pend_count = 0;
            seq_len = 0;
            cells_shown = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Accept side: mirror register writes, predict on every taken word,
    // check every delivered word against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cell_word w;
        if (i_rst_n) begin
            if (i_cfg_we) width_reg = i_cfg_wdata;
            if (push && !full) predict_cells(i_text_byte, i_end_of_text);
            if (pop && !empty) begin
                if (cells_due.size() == 0) begin
                    report_mismatch("unexpected word", o_cell_pattern, 0);
                end else begin
                    w = cells_due.pop_front();
                    if (o_cell_pattern !== w.pattern)
                        report_mismatch("cell_pattern", o_cell_pattern, w.pattern);
                    if (o_has_cell !== w.has_cell)
                        report_mismatch("has_cell", o_has_cell, w.has_cell);
                    if (o_cell_index !== w.index)
                        report_mismatch("cell_index", o_cell_index, w.index);
                    if (o_text_done !== w.done)
                        report_mismatch("text_done", o_text_done, w.done);
                end
            end
        end
    end

    // Driver: present the next queued byte after a random gap; hold it until taken.
    always @(posedge i_clk) begin
        t_text_word tw;
        logic       nxt_push;
        nxt_push = push;
        if (i_rst_n) begin
            if (push && !full) begin
                nxt_push = 1'b0;
                send_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (!nxt_push) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (text_words.size() > 0) begin
                    tw = text_words.pop_front();
                    i_text_byte <= tw.text_byte;
                    i_end_of_text <= tw.eot;
                    nxt_push = 1'b1;
                end
            end
        end
        push <= nxt_push;
    end

    // Receiver: stall a random number of cycles after each taken word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) recv_gap = no_idle ? 0 : $urandom_range(0, 5);
            else if (recv_gap > 0) recv_gap--;
            pop <= (recv_gap == 0) && !(pop && !empty && !no_idle && recv_gap != 0);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_word(input logic [7:0] b, input logic eot);
        text_words.push_back('{b, eot});
    endtask

    // Queue a string; end_of_text rides on its last byte.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_word(s[i], i == s.len() - 1);
    endtask

    task automatic add_point(input int cp, input int n);
        case (n)
            2: begin
                add_word(8'hC0 | cp[10:6], 1'b0);
                add_word(8'h80 | cp[5:0], 1'b0);
            end
            3: begin
                add_word(8'hE0 | cp[15:12], 1'b0);
                add_word(8'h80 | cp[11:6], 1'b0);
                add_word(8'h80 | cp[5:0], 1'b0);
            end
            default: begin
                add_word(8'hF0 | cp[20:18], 1'b0);
                add_word(8'h80 | cp[17:12], 1'b0);
                add_word(8'h80 | cp[11:6], 1'b0);
                add_word(8'h80 | cp[5:0], 1'b0);
            end
        endcase
    endtask

    // Mostly well-formed text with random content, some noise and cut-off sequences.
    task automatic add_random_text();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_word(8'($urandom_range(1, 127)), 1'b0);
                4: add_point($urandom_range('h80, 'h7FF), 2);
                5, 6: add_point($urandom_range('h900, 'h97F), 3);
                7: add_point($urandom_range(0, 'h1FFFFF), 4);
                8: add_word(8'($urandom_range(1, 255)), 1'b0);
                default: begin
                    add_word(8'($urandom_range('hC0, 'hF7)), 1'b0);
                    repeat ($urandom_range(0, 2)) add_word(8'($urandom_range(1, 255)), 1'b0);
                end
            endcase
        end
        // close with a zero byte or with end_of_text on the last byte
        if ($urandom_range(0, 2) == 0) add_word(8'h00, 1'($urandom_range(0, 1)));
        else text_words[text_words.size() - 1].eot = 1'b1;
    endtask

    // Wait until every byte is taken and every cell has come, then let the block settle.
    task automatic drain();
        while (text_words.size() > 0 || push || cells_due.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [6:0] v);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [6:0] widths [0:5];
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_text_byte = 8'h00;
        i_end_of_text = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 7'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset width of 20, every ASCII class and the special bytes.
        add_text("Az09.,;:!?-'\"()/\\+=*&%@#[]<>_ ");
        add_word(8'h09, 1'b0);
        add_word(8'h0A, 1'b0);
        add_word(8'h0D, 1'b0);
        add_word(8'h7F, 1'b0);
        add_word(8'h80, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'hF8, 1'b0);
        add_point('h0E9, 2);
        add_point('h905, 3);
        add_point('h94D, 3);
        add_point('h964, 3);
        add_point('h1F600, 4);
        add_word(8'h00, 1'b0);
        // Cut-off four-byte sequence ended by a zero byte: three question marks.
        add_word(8'hF0, 1'b0);
        add_word(8'h9F, 1'b0);
        add_word(8'h98, 1'b0);
        add_word(8'h00, 1'b1);
        // Lead followed by plain ASCII, ended by end_of_text: '?', then 'a'.
        add_word(8'hE0, 1'b0);
        add_word(8'h61, 1'b1);
        // Empty text: a bare end marker.
        add_word(8'h00, 1'b0);
        drain();

        // Narrowest display: only each text's first cell shows; "abc" ends with a bare marker.
        write_width(7'd1);
        add_text("abc");
        add_word(8'hF0, 1'b0);
        add_word(8'h41, 1'b0);
        add_word(8'h00, 1'b0);
        drain();

        // Random phases across widths, extremes among them.
        widths = '{7'd0, 7'd80, 7'd127, 7'd3, 7'd1, 7'd20};
        for (int p = 0; p < 6; p++) begin
            write_width(p == 5 ? 7'($urandom_range(1, 80)) : widths[p]);
            no_idle = (p == 2);
            add_random_text();
            drain();
            no_idle = 1'b0;
        end

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
